// ===== rtl/ckhs_pkg.sv =====
// ----------------------------------------------------------------------------
// ckhs_pkg
// Shared types, constants and the CRC-16 byte update of the key hash slot.
// ----------------------------------------------------------------------------
package ckhs_pkg;

  localparam logic [7:0]  OPEN_BRACE     = 8'h7B;
  localparam logic [7:0]  CLOSE_BRACE    = 8'h7D;
  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [15:0] SLOT_MASK_RST  = 16'd16383;

  // Command queue between front and back
  localparam int QDepth  = 4;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int QCntW   = $clog2(QDepth + 1);

  // One classified key byte
  typedef struct packed {
    logic [7:0] key_byte;
    logic       feed_tag;   // byte lies inside an open tag
    logic       last_byte;  // end of key, emit a slot
    logic       use_tag;    // on the last byte: slot comes from the tag CRC
    logic       empty_key;  // key without bytes, emit slot 0
  } ckhs_cmd_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } ckhs_qstat_t;

  // CRC-16 XMODEM update with one byte, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/cluster_key_hash_slot.sv =====
// ----------------------------------------------------------------------------
// cluster_key_hash_slot
// Cluster hash slot of a key fed one byte per item, with brace hash tags.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the key on the in_ channel, one byte per item, in order; mark the
//   final byte with in_last_byte. An item with in_empty_key set stands for a
//   key with no bytes and yields slot 0 at once, dropping any partial key.
//   One item comes out on the out_ channel per key: out_slot is the CRC-16
//   (XMODEM) of the hash tag between the first '{' and the next '}' when that
//   tag is non-empty, otherwise of the whole key, ANDed with the slot mask.
//   The cfg_ channel writes the slot mask; write it only while idle.
// Timing:
//   One byte per cycle sustained while out_ready is high. The last byte is
//   first written into the command queue; once the bytes ahead of it have
//   left the queue, the back end runs the CRC unit on it and loads the
//   output register, which drives out_valid.
// Reset and stalls:
//   Reset clears all key state and sets the mask to 16383. While a result
//   waits with out_ready low, the back end keeps folding non-final bytes and
//   holds at the next final byte; the four-entry queue absorbs bytes until
//   full, then in_ready drops.
// ----------------------------------------------------------------------------
module cluster_key_hash_slot import ckhs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_key_byte,
  input  logic        in_last_byte,
  input  logic        in_empty_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_slot,
  output logic        out_used_tag,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_slot_mask
);

  logic [15:0] slot_mask_r, slot_mask_nxt;
  logic        push_valid;
  ckhs_cmd_t   push_cmd;
  ckhs_cmd_t   head_cmd;
  ckhs_qstat_t q_stat;
  logic        pop;

  // Mask register: always ready, take the write on handshake
  assign cfg_ready     = 1'b1;
  assign slot_mask_nxt = (cfg_valid && cfg_ready) ? cfg_slot_mask : slot_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_mask_r <= SLOT_MASK_RST;
    end else begin
      slot_mask_r <= slot_mask_nxt;
    end
  end

  // Front: accept bytes, track the tag, classify
  ckhs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_key_byte  (in_key_byte),
    .in_last_byte (in_last_byte),
    .in_empty_key (in_empty_key),
    .q_stat       (q_stat),
    .push_valid   (push_valid),
    .push_cmd     (push_cmd)
  );

  // Decouple front from back
  ckhs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head_cmd   (head_cmd),
    .q_stat     (q_stat)
  );

  // Back: run the CRCs, hold the result until taken
  ckhs_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .slot_mask    (slot_mask_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_slot     (out_slot),
    .out_used_tag (out_used_tag)
  );

  // Slot never has bits outside the mask
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_slot & ~slot_mask_r) == 16'h0000))
    else $error("slot has bits outside the mask");

  // Queue can not be full and empty at once
  assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

  // Back end never pops from an empty queue
  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // No result right after reset
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

// ===== rtl/ckhs_front.sv =====
// ----------------------------------------------------------------------------
// ckhs_front
// Accept key bytes, follow the brace hash tag and push classified commands.
// ----------------------------------------------------------------------------
module ckhs_front import ckhs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_key_byte,
  input  logic        in_last_byte,
  input  logic        in_empty_key,
  input  ckhs_qstat_t q_stat,
  output logic        push_valid,
  output ckhs_cmd_t   push_cmd
);

  typedef enum logic [1:0] {
    SEEK   = 2'd0,
    IN_TAG = 2'd1,
    CLOSED = 2'd2
  } phase_t;

  phase_t phase_r, phase_nxt, phase_upd;
  logic   nonempty_r, nonempty_nxt, nonempty_upd;
  logic   feed_tag;
  logic   accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_upd    = phase_r;
    nonempty_upd = nonempty_r;
    feed_tag     = 1'b0;
    unique case (phase_r)
      SEEK: begin
        if (in_key_byte == OPEN_BRACE) begin
          phase_upd = IN_TAG;
        end
      end
      IN_TAG: begin
        if (in_key_byte == CLOSE_BRACE) begin
          phase_upd = CLOSED;
        end else begin
          feed_tag     = 1'b1;
          nonempty_upd = 1'b1;
        end
      end
      CLOSED: ;
      default: phase_upd = CLOSED;
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    nonempty_nxt = nonempty_r;
    if (accept) begin
      if (in_empty_key || in_last_byte) begin
        // key done: start over for the next key
        phase_nxt    = SEEK;
        nonempty_nxt = 1'b0;
      end else begin
        phase_nxt    = phase_upd;
        nonempty_nxt = nonempty_upd;
      end
    end
  end

  assign push_valid         = accept;
  assign push_cmd.key_byte  = in_key_byte;
  assign push_cmd.feed_tag  = feed_tag;
  assign push_cmd.last_byte = in_last_byte;
  assign push_cmd.use_tag   = (phase_upd == CLOSED) && nonempty_upd;
  assign push_cmd.empty_key = in_empty_key;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= SEEK;
      nonempty_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      nonempty_r <= nonempty_nxt;
    end
  end

endmodule

// ===== rtl/ckhs_queue.sv =====
// ----------------------------------------------------------------------------
// ckhs_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module ckhs_queue import ckhs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  input  ckhs_cmd_t   push_cmd,
  input  logic        pop,
  output ckhs_cmd_t   head_cmd,
  output ckhs_qstat_t q_stat
);

  ckhs_cmd_t         slots_r [QDepth];
  logic [QPtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign q_stat.full  = (count_r == QCntW'(QDepth));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push_valid && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_cmd     = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/ckhs_back.sv =====
// ----------------------------------------------------------------------------
// ckhs_back
// Run both CRCs over queued commands and register the slot result.
// ----------------------------------------------------------------------------
module ckhs_back import ckhs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ckhs_qstat_t q_stat,
  input  ckhs_cmd_t   head_cmd,
  output logic        pop,
  input  logic [15:0] slot_mask,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_slot,
  output logic        out_used_tag
);

  logic [15:0] whole_crc_r, whole_crc_nxt;
  logic [15:0] tag_crc_r, tag_crc_nxt;
  logic [15:0] whole_upd, tag_upd;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] slot_r, slot_nxt;
  logic        used_tag_r, used_tag_nxt;
  logic        emits;

  assign emits     = head_cmd.last_byte || head_cmd.empty_key;
  // Pop unless this command would overwrite an untaken result
  assign pop       = !q_stat.empty && (!emits || !out_valid_r || out_ready);
  assign whole_upd = crc_feed(whole_crc_r, head_cmd.key_byte);
  assign tag_upd   = head_cmd.feed_tag ? crc_feed(tag_crc_r, head_cmd.key_byte) : tag_crc_r;

  always_comb begin
    whole_crc_nxt = whole_crc_r;
    tag_crc_nxt   = tag_crc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    slot_nxt      = slot_r;
    used_tag_nxt  = used_tag_r;
    if (pop) begin
      if (head_cmd.empty_key) begin
        whole_crc_nxt = '0;
        tag_crc_nxt   = '0;
        out_valid_nxt = 1'b1;
        slot_nxt      = '0;
        used_tag_nxt  = 1'b0;
      end else if (head_cmd.last_byte) begin
        whole_crc_nxt = '0;
        tag_crc_nxt   = '0;
        out_valid_nxt = 1'b1;
        slot_nxt      = (head_cmd.use_tag ? tag_upd : whole_upd) & slot_mask;
        used_tag_nxt  = head_cmd.use_tag;
      end else begin
        whole_crc_nxt = whole_upd;
        tag_crc_nxt   = tag_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    used_tag_r <= used_tag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      whole_crc_r <= '0;
      tag_crc_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      whole_crc_r <= whole_crc_nxt;
      tag_crc_r   <= tag_crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_slot     = slot_r;
  assign out_used_tag = used_tag_r;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for cluster_key_hash_slot: keys are streamed in one byte
// per item, and each slot that comes out is compared with a CRC-16 prediction
// kept by a small scoreboard. Directed keys cover brace corners; random keys
// follow under several slot masks and sender/receiver stall patterns.
// ----------------------------------------------------------------------------
module testbench;
  import ckhs_pkg::*;

  // Scoreboard: track the key in progress and hold the slots still owed.
  class slot_scoreboard;
    typedef enum logic [1:0] {SEEK_OPEN, IN_TAG, TAG_DONE} tag_state_t;

    logic [15:0] mask;
    tag_state_t  tag_state;
    logic [15:0] key_crc;
    logic [15:0] tag_crc;
    logic        tag_has_bytes;
    logic [15:0] slot_q[$];
    logic        used_tag_q[$];
    int          errors;

    function new();
      mask   = SLOT_MASK_RST;
      errors = 0;
      clear_key();
    endfunction

    function void clear_key();
      tag_state     = SEEK_OPEN;
      key_crc       = '0;
      tag_crc       = '0;
      tag_has_bytes = 1'b0;
    endfunction

    // Fold one byte into the CRC, one message bit at a time, MSB first.
    static function logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb  = crc[15] ^ b[i];
        crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return crc;
    endfunction

    function void set_mask(logic [15:0] m);
      mask = m;
    endfunction

    function int pending();
      return slot_q.size();
    endfunction

    // Note one accepted item and queue the slot it causes, if any.
    function void note_item(logic [7:0] b, logic last, logic empty);
      if (empty) begin
        clear_key();
        slot_q.push_back(16'h0000);
        used_tag_q.push_back(1'b0);
        return;
      end
      key_crc = crc16_byte(key_crc, b);
      case (tag_state)
        SEEK_OPEN: begin
          if (b == OPEN_BRACE) tag_state = IN_TAG;
        end
        IN_TAG: begin
          if (b == CLOSE_BRACE) begin
            tag_state = TAG_DONE;
          end else begin
            tag_crc       = crc16_byte(tag_crc, b);
            tag_has_bytes = 1'b1;
          end
        end
        default: ;
      endcase
      if (last) begin
        if (tag_state == TAG_DONE && tag_has_bytes) begin
          slot_q.push_back(tag_crc & mask);
          used_tag_q.push_back(1'b1);
        end else begin
          slot_q.push_back(key_crc & mask);
          used_tag_q.push_back(1'b0);
        end
        clear_key();
      end
    endfunction

    // Compare one result with the oldest slot owed.
    function void check_result(logic [15:0] slot, logic used_tag);
      logic [15:0] exp_slot;
      logic        exp_used_tag;
      if (slot_q.size() == 0) begin
        $error("unexpected result: slot %0h used_tag %0b", slot, used_tag);
        errors++;
        return;
      end
      exp_slot     = slot_q.pop_front();
      exp_used_tag = used_tag_q.pop_front();
      if (slot !== exp_slot) begin
        $error("slot mismatch: expected %0h, actual %0h", exp_slot, slot);
        errors++;
      end
      if (used_tag !== exp_used_tag) begin
        $error("used_tag mismatch: expected %0b, actual %0b", exp_used_tag, used_tag);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_key_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        in_empty_key = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_slot;
  logic        out_used_tag;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_slot_mask = '0;

  // Stall rates in percent of cycles, changed between phases.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  slot_scoreboard sb = new();

  cluster_key_hash_slot u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_key_byte  (in_key_byte),
    .in_last_byte (in_last_byte),
    .in_empty_key (in_empty_key),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_slot     (out_slot),
    .out_used_tag (out_used_tag),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_slot_mask(cfg_slot_mask)
  );

  always #6 clk = ~clk;

  // Receiver: drop ready at random at the falling edge, per the current rate.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Check every result taken at a rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_slot, out_used_tag);
    end
  end

  // Hard limit on the run in case the block hangs.
  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Present one item and hold it until taken. Call at a falling edge; returns
  // at the falling edge after acceptance with valid still high.
  task automatic send_item(logic [7:0] b, logic last, logic empty);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid     <= 1'b1;
    in_key_byte  <= b;
    in_last_byte <= last;
    in_empty_key <= empty;
    do @(posedge clk); while (!in_ready);
    sb.note_item(b, last, empty);
    @(negedge clk);
  endtask

  // Stream a whole key given as text, last flag on the final byte.
  task automatic send_text_key(string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], i == s.len() - 1, 1'b0);
    end
  endtask

  // Drain all owed slots, then give the byte queue time to empty too.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_mask(logic [15:0] m);
    cfg_valid     <= 1'b1;
    cfg_slot_mask <= m;
    do @(posedge clk); while (!cfg_ready);
    sb.set_mask(m);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Favor braces and letters so tags form often; keep full-range bytes too.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 15) return OPEN_BRACE;
    if (r < 27) return CLOSE_BRACE;
    if (r < 62) return 8'($urandom_range(8'h7A, 8'h61));
    return 8'($urandom_range(255));
  endfunction

  // Build and send one random key; add the number of items sent to count.
  task automatic send_random_key(inout int count);
    logic [7:0] key_q[$];
    int         len;
    int         cut;
    if ($urandom_range(99) < 5) begin
      // lone empty key, byte and last flag are don't-care
      send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      count++;
      return;
    end
    if ($urandom_range(99) < 65) begin
      // prefix, tag, optional close, suffix
      repeat ($urandom_range(4)) key_q.push_back(pick_byte());
      key_q.push_back(OPEN_BRACE);
      repeat ($urandom_range(5)) key_q.push_back(pick_byte());
      if ($urandom_range(99) < 85) key_q.push_back(CLOSE_BRACE);
      repeat ($urandom_range(4)) key_q.push_back(pick_byte());
    end else begin
      len = ($urandom_range(99) < 8) ? $urandom_range(40, 12) : $urandom_range(8, 1);
      repeat (len) key_q.push_back(pick_byte());
    end
    if (key_q.size() > 1 && $urandom_range(99) < 6) begin
      // abandon the key partway with an empty key
      cut = $urandom_range(key_q.size() - 1, 1);
      for (int i = 0; i < cut; i++) send_item(key_q[i], 1'b0, 1'b0);
      send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      count += cut + 1;
      return;
    end
    for (int i = 0; i < key_q.size(); i++) begin
      send_item(key_q[i], i == key_q.size() - 1, 1'b0);
    end
    count += key_q.size();
  endtask

  task automatic run_random(int budget);
    int count;
    count = 0;
    while (count < budget) send_random_key(count);
  endtask

  initial begin
    // Hold reset, then release it at a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed keys, full mask so the whole CRC shows.
    tx_idle_pct = 28;
    rx_idle_pct = 60;
    write_mask(16'hFFFF);
    send_item(8'hFF, 1'b1, 1'b1);          // empty key, other fields ignored
    send_item(8'h00, 1'b1, 1'b0);          // single low byte
    send_item(8'hFF, 1'b1, 1'b0);          // single high byte
    send_text_key("{a}");                  // plain tag
    send_text_key("{}");                   // empty tag falls back to key CRC
    send_text_key("{{b}");                 // inner open brace is a tag byte
    send_text_key("{ab");                  // tag never closed
    send_text_key("{b}c{");                // bytes after close skip the tag
    send_text_key("}{z}");                 // close before open is ordinary
    send_item(OPEN_BRACE, 1'b0, 1'b0);     // partial key, then drop it
    send_item(OPEN_BRACE, 1'b1, 1'b1);
    settle();

    // Random keys under several masks and stall patterns.
    write_mask(SLOT_MASK_RST);
    run_random(150);
    settle();

    tx_idle_pct = 60;
    rx_idle_pct = 28;
    write_mask(16'h0000);
    run_random(60);
    settle();

    write_mask(16'($urandom_range(16'hFFFF)));
    run_random(90);
    settle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_mask(16'hFFFF);
    run_random(150);
    settle();

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ckhs_pkg.sv
rtl/ckhs_front.sv
rtl/ckhs_queue.sv
rtl/ckhs_back.sv
rtl/cluster_key_hash_slot.sv
tb/sv/testbench.sv
